/* hdl/te_pkg.sv */
// te_pkg: shared types and constants of the tab expander
// item kinds, queue entry, configuration bundle and field widths
// no dependencies
package te_pkg;

    // line and tab stop limits
    localparam int LINE_MAX   = 1024;
    localparam int LIST_STOPS = 6;

    // field and state widths
    localparam int CHAR_W = 8;
    localparam int COL_W  = 11;
    localparam int NS_W   = 12;
    localparam int STOP_W = 10;
    localparam int STEP_W = 7;
    localparam int IDX_W  = $clog2(LIST_STOPS + 1);
    localparam int CFG_W  = 3;

    // character codes
    localparam logic [CHAR_W-1:0] CH_END   = 8'd0;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

    // configuration register indexes
    localparam logic [CFG_W-1:0] CFG_STOP_A   = 3'd0;
    localparam logic [CFG_W-1:0] CFG_TAB_STEP = 3'd6;

    // item classes decided at the front
    typedef enum logic [1:0] {
        K_CHAR,
        K_SPACE,
        K_TAB,
        K_END
    } t_kind;

    // one queue entry
    typedef struct packed {
        t_kind             kind;
        logic [CHAR_W-1:0] ch;
    } t_item;

    // live configuration seen by the back end
    typedef struct packed {
        logic [LIST_STOPS-1:0][STOP_W-1:0] stops;
        logic [STEP_W-1:0]                 tab_step;
    } t_cfg;

endpackage

/* hdl/te_front.sv */
// te_front: accepts input items and classifies each byte
// depends on te_pkg; feeds te_queue
module te_front import te_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [CHAR_W-1:0] i_char_in,
    input  logic              i_q_full,
    output logic              o_stall,
    output logic              o_push,
    output t_item             o_item
);

    // hold the sender off while the queue is full
    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // byte classification
    always_comb begin
        o_item.ch = i_char_in;
        if (i_char_in == CH_END) begin
            o_item.kind = K_END;
        end else if (i_char_in == CH_TAB) begin
            o_item.kind = K_TAB;
        end else if (i_char_in == CH_SPACE) begin
            o_item.kind = K_SPACE;
        end else begin
            o_item.kind = K_CHAR;
        end
    end

    // a push never happens against a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_full) else $error("push into full queue");

endmodule

/* hdl/te_queue.sv */
// te_queue: two-entry queue between the front and the back end
// depends on te_pkg
module te_queue import te_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_head
);

    t_item       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        n_wr_ptr;
    logic        n_rd_ptr;
    logic [1:0]  n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_mem[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = !r_wr_ptr;
        end
        if (i_pop) begin
            n_rd_ptr = !r_rd_ptr;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2) else $error("queue count out of range");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop from empty queue");
    a_ptrs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule

/* hdl/te_back.sv */
// te_back: line state, tab stop advance and result register
// depends on te_pkg; takes items from te_queue
module te_back import te_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_q_valid,
    input  t_item             i_q_head,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [COL_W-1:0]  o_pad_spaces,
    output logic [CHAR_W-1:0] o_char_out,
    output logic              o_line_end
);

    localparam logic [COL_W-1:0] LMAX = COL_W'(LINE_MAX);

    logic [COL_W-1:0]  r_column;
    logic [COL_W-1:0]  r_pending;
    logic [NS_W-1:0]   r_next_stop;
    logic [IDX_W-1:0]  r_stop_idx;
    logic              r_o_valid;
    logic [COL_W-1:0]  r_o_pad;
    logic [CHAR_W-1:0] r_o_char;
    logic              r_o_line_end;

    logic [COL_W-1:0]  n_column;
    logic [COL_W-1:0]  n_pending;
    logic [NS_W-1:0]   n_next_stop;
    logic [IDX_W-1:0]  n_stop_idx;
    logic              n_o_valid;
    logic [COL_W-1:0]  n_o_pad;
    logic [CHAR_W-1:0] n_o_char;
    logic              n_o_line_end;

    logic              out_free;
    logic [NS_W-1:0]   pos;
    logic              need_step;
    logic [STEP_W-1:0] step;
    logic [STOP_W-1:0] list_stop;
    logic [COL_W-1:0]  room;
    logic [NS_W-1:0]   tab_gap;
    logic [NS_W:0]     total;
    logic [COL_W-1:0]  sat_pending;

    assign out_free = !r_o_valid || !i_stall;

    // position the next byte would land on, and the next stop test
    assign pos       = NS_W'(r_column) + NS_W'(r_pending);
    assign need_step = (pos >= r_next_stop);
    assign step      = (i_cfg.tab_step == '0) ? STEP_W'(1) : i_cfg.tab_step;

    // current listed stop, zero once the list is used up
    always_comb begin
        list_stop = '0;
        if (r_stop_idx < IDX_W'(LIST_STOPS)) begin
            list_stop = i_cfg.stops[r_stop_idx];
        end
    end

    // blanks added by this item, clipped at the end of the line
    assign room    = LMAX - r_column;
    assign tab_gap = r_next_stop - pos;
    always_comb begin
        if (i_q_head.kind == K_TAB) begin
            total = (NS_W+1)'(r_pending) + (NS_W+1)'(tab_gap);
        end else begin
            total = (NS_W+1)'(r_pending) + (NS_W+1)'(1);
        end
        sat_pending = (total > (NS_W+1)'(room)) ? room : total[COL_W-1:0];
    end

    // item execution: one tab stop step or one item per cycle, unless a stalled output holds a character or line end
    always_comb begin
        n_column     = r_column;
        n_pending    = r_pending;
        n_next_stop  = r_next_stop;
        n_stop_idx   = r_stop_idx;
        n_o_valid    = r_o_valid && i_stall;
        n_o_pad      = r_o_pad;
        n_o_char     = r_o_char;
        n_o_line_end = r_o_line_end;
        o_q_pop      = 1'b0;
        if (i_q_valid) begin
            if (i_q_head.kind == K_END) begin
                if (out_free) begin
                    n_o_valid    = 1'b1;
                    n_o_pad      = '0;
                    n_o_char     = CH_END;
                    n_o_line_end = 1'b1;
                    n_column     = '0;
                    n_pending    = '0;
                    n_next_stop  = '0;
                    n_stop_idx   = '0;
                    o_q_pop      = 1'b1;
                end
            end else if (r_column > LMAX) begin
                // past the line limit: drop the byte
                o_q_pop = 1'b1;
            end else if (need_step) begin
                // move the next stop forward by one stop
                if (list_stop != '0) begin
                    n_next_stop = NS_W'(list_stop);
                    n_stop_idx  = r_stop_idx + IDX_W'(1);
                end else begin
                    n_stop_idx  = IDX_W'(LIST_STOPS);
                    n_next_stop = r_next_stop + NS_W'(step);
                end
            end else begin
                case (i_q_head.kind)
                    K_SPACE, K_TAB: begin
                        n_pending = sat_pending;
                        o_q_pop   = 1'b1;
                    end
                    K_CHAR: begin
                        if (out_free) begin
                            n_o_valid    = 1'b1;
                            n_o_pad      = r_pending;
                            n_o_char     = i_q_head.ch;
                            n_o_line_end = 1'b0;
                            n_column     = r_column + r_pending + COL_W'(1);
                            n_pending    = '0;
                            o_q_pop      = 1'b1;
                        end
                    end
                    default: begin
                        o_q_pop = 1'b0;
                    end
                endcase
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column    <= '0;
            r_pending   <= '0;
            r_next_stop <= '0;
            r_stop_idx  <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_column    <= n_column;
            r_pending   <= n_pending;
            r_next_stop <= n_next_stop;
            r_stop_idx  <= n_stop_idx;
            r_o_valid   <= n_o_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_o_pad      <= n_o_pad;
        r_o_char     <= n_o_char;
        r_o_line_end <= n_o_line_end;
    end

    assign o_valid      = r_o_valid;
    assign o_pad_spaces = r_o_pad;
    assign o_char_out   = r_o_char;
    assign o_line_end   = r_o_line_end;

    a_pending_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_column <= LMAX) |-> (pos <= NS_W'(LINE_MAX)))
        else $error("pending blanks run past line limit");
    a_column_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_column <= LMAX + COL_W'(1)) else $error("column out of range");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stop_idx <= IDX_W'(LIST_STOPS)) else $error("stop index out of range");
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q_head.kind == K_END) |=>
        (r_column == '0 && r_pending == '0 && r_o_line_end && r_o_valid))
        else $error("line end did not clear the line state");

endmodule

/* hdl/tab_expander_core.sv */
// tab_expander_core: top level of the tab expander, holds the configuration registers
// depends on te_pkg, te_front, te_queue, te_back
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  input    | i_valid / o_stall    | i_char_in
//  output   | o_valid / i_stall    | o_pad_spaces, o_char_out, o_line_end
//  config   | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// An item moves into a two-entry queue on the edge it is accepted; the back end then
// handles queued items in order, first moving the next stop across each tab stop that
// lies before the byte, and writes each character or line end to the output register.
// A result thus waits behind every item still queued ahead and every tab stop crossed.
// Reset is synchronous: line state clears, stop_a returns to 8, tab_step to 8, others 0.
// A stalled output holds the result; the queue keeps taking items until it fills.
module tab_expander_core import te_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CHAR_W-1:0] i_char_in,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [COL_W-1:0]  o_pad_spaces,
    output logic [CHAR_W-1:0] o_char_out,
    output logic              o_line_end,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_idx,
    input  logic [STOP_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    logic  q_full;
    logic  q_push;
    t_item q_in;
    logic  q_pop;
    logic  q_valid;
    t_item q_head;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // stop_a sits in the low entry, every other listed stop clears
            r_cfg.stops    <= (LIST_STOPS*STOP_W)'(8);
            r_cfg.tab_step <= STEP_W'(8);
        end else if (i_cfg_we) begin
            if (i_cfg_idx < CFG_W'(LIST_STOPS)) begin
                r_cfg.stops[i_cfg_idx] <= i_cfg_data;
            end else if (i_cfg_idx == CFG_TAB_STEP) begin
                r_cfg.tab_step <= i_cfg_data[STEP_W-1:0];
            end
        end
    end

    // front: accept and classify
    te_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_char_in (i_char_in),
        .i_q_full  (q_full),
        .o_stall   (o_stall),
        .o_push    (q_push),
        .o_item    (q_in)
    );

    // queue between front and back
    te_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // back: line state and results
    te_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_valid    (q_valid),
        .i_q_head     (q_head),
        .o_q_pop      (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pad_spaces (o_pad_spaces),
        .o_char_out   (o_char_out),
        .o_line_end   (o_line_end)
    );

endmodule
